/* sv/iae_pkg.sv */
`timescale 1ns / 1ps
package iae_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int FRAC_BITS   = 24;
  localparam int VAL_W       = 48;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int HALF_W      = VAL_W / 2;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int DIVD_W      = VAL_W + FRAC_BITS;
  localparam int DCNT_W      = $clog2(DIVD_W + 1);
  localparam int SCALE_W     = FRAC_BITS;
  localparam int INT_W       = VAL_W + 4;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  localparam logic [VAL_W-1:0] MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MIN_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  // one tenth, rounded half up
  localparam logic [SCALE_W-1:0] TENTH =
    SCALE_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  // floor(v / 10) == (v * RECIP10) >> RECIP_SH for any 32-bit v
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // bit 1 is the precedence class
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2,
    ST_MALF = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIG_NONE  = 2'd0,
    DIG_START = 2'd1,
    DIG_INT   = 2'd2,
    DIG_FRAC  = 2'd3
  } dig_e;

  typedef struct packed {
    dig_e              dig;
    logic [3:0]        digit;
    logic              num_we;
    logic              num_wsel_res;
    logic [ADDR_W-1:0] num_waddr;
    logic [ADDR_W-1:0] num_raddr;
    logic              op_we;
    logic [ADDR_W-1:0] op_waddr;
    op_e               op_wdata;
    logic [ADDR_W-1:0] op_raddr;
    logic              load_y;
    logic              alu_start;
    logic              out_load;
    logic              out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic digit_ovf;
    logic alu_done;
    logic alu_ovf;
    logic alu_div0;
    op_e  op_top;
  } dp_stat_t;

  // divide by zero and malformed input lock the status; overflow yields to them
  function automatic status_e raise_err(input status_e cur, input status_e code);
    if (cur == ST_OK || (cur == ST_OVF && code != ST_OVF)) begin
      return code;
    end
    return cur;
  endfunction

endpackage

/* sv/iae_ram.sv */
`timescale 1ns / 1ps
module iae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/iae_alu.sv */
`timescale 1ns / 1ps
module iae_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  iae_pkg::op_e            op_i,
  input  logic [iae_pkg::VAL_W-1:0] x_i,
  input  logic [iae_pkg::VAL_W-1:0] y_i,
  output logic                    done_o,
  output logic [iae_pkg::VAL_W-1:0] res_o,
  output logic                    ovf_o,
  output logic                    div0_o
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ADD  = 6'b000010,
    A_MUL  = 6'b000100,
    A_DIV  = 6'b001000,
    A_SAT  = 6'b010000,
    A_DONE = 6'b100000
  } alu_state_e;

  alu_state_e state_q, state_d;

  logic [iae_pkg::VAL_W-1:0]      a_q, b_q, ma_q, mb_q;
  logic                           neg_q;
  iae_pkg::op_e                   op_q;
  logic [iae_pkg::DCNT_W-1:0]     cnt_q;
  logic [iae_pkg::VAL_W-1:0]      pp_q;
  logic [1:0]                     sh_q;
  logic [iae_pkg::PROD_W-1:0]     acc_q;
  logic [iae_pkg::VAL_W:0]        rem_q;
  logic [iae_pkg::DIVD_W-1:0]     quo_q, dvd_q;
  logic [iae_pkg::VAL_W-1:0]      res_q;
  logic                           ovf_q, div0_q;

  logic [iae_pkg::VAL_W-1:0]      mag_x, mag_y;
  logic [iae_pkg::VAL_W:0]        sum;
  logic [iae_pkg::HALF_W-1:0]     ha, hb;
  logic [iae_pkg::PROD_W-1:0]     pp_sh;
  logic [iae_pkg::VAL_W:0]        rem_sh;
  logic                           rem_ge;
  logic [iae_pkg::PROD_W-1:0]     wide;

  assign mag_x = x_i[iae_pkg::VAL_W-1] ? (~x_i + 1'b1) : x_i;
  assign mag_y = y_i[iae_pkg::VAL_W-1] ? (~y_i + 1'b1) : y_i;

  assign sum = (op_q == iae_pkg::OP_SUB)
             ? ({a_q[iae_pkg::VAL_W-1], a_q} - {b_q[iae_pkg::VAL_W-1], b_q})
             : ({a_q[iae_pkg::VAL_W-1], a_q} + {b_q[iae_pkg::VAL_W-1], b_q});

  assign ha = cnt_q[0] ? ma_q[iae_pkg::VAL_W-1:iae_pkg::HALF_W] : ma_q[iae_pkg::HALF_W-1:0];
  assign hb = cnt_q[1] ? mb_q[iae_pkg::VAL_W-1:iae_pkg::HALF_W] : mb_q[iae_pkg::HALF_W-1:0];

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_sh = iae_pkg::PROD_W'(pp_q);
      2'd1:    pp_sh = iae_pkg::PROD_W'(pp_q) << iae_pkg::HALF_W;
      default: pp_sh = iae_pkg::PROD_W'(pp_q) << (2 * iae_pkg::HALF_W);
    endcase
  end

  assign rem_sh = {rem_q[iae_pkg::VAL_W-1:0], dvd_q[iae_pkg::DIVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, mb_q};

  assign wide = (op_q == iae_pkg::OP_MUL) ? (acc_q >> iae_pkg::FRAC_BITS)
                                          : iae_pkg::PROD_W'(quo_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            iae_pkg::OP_ADD, iae_pkg::OP_SUB: state_d = A_ADD;
            iae_pkg::OP_MUL:                  state_d = A_MUL;
            default:                          state_d = (mag_y == '0) ? A_DONE : A_DIV;
          endcase
        end
      end
      A_ADD: state_d = A_DONE;
      A_MUL: if (cnt_q == iae_pkg::DCNT_W'(4)) state_d = A_SAT;
      A_DIV: if (cnt_q == iae_pkg::DCNT_W'(iae_pkg::DIVD_W - 1)) state_d = A_SAT;
      A_SAT: state_d = A_DONE;
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          a_q    <= x_i;
          b_q    <= y_i;
          ma_q   <= mag_x;
          mb_q   <= mag_y;
          neg_q  <= x_i[iae_pkg::VAL_W-1] ^ y_i[iae_pkg::VAL_W-1];
          op_q   <= op_i;
          cnt_q  <= '0;
          acc_q  <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          dvd_q  <= {mag_x, {iae_pkg::FRAC_BITS{1'b0}}};
          ovf_q  <= 1'b0;
          div0_q <= (op_i == iae_pkg::OP_DIV) && (mag_y == '0);
          res_q  <= '0;
        end
      end
      A_ADD: begin
        if (!sum[iae_pkg::VAL_W] && sum[iae_pkg::VAL_W-1]) begin
          res_q <= iae_pkg::MAX_POS;
          ovf_q <= 1'b1;
        end else if (sum[iae_pkg::VAL_W] && !sum[iae_pkg::VAL_W-1]) begin
          res_q <= iae_pkg::MIN_NEG;
          ovf_q <= 1'b1;
        end else begin
          res_q <= sum[iae_pkg::VAL_W-1:0];
        end
      end
      A_MUL: begin
        // partial product registered, accumulated in the next cycle
        pp_q  <= ha * hb;
        sh_q  <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
        if (cnt_q != '0) begin
          acc_q <= acc_q + pp_sh;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      A_DIV: begin
        dvd_q <= dvd_q << 1;
        if (rem_ge) begin
          rem_q <= rem_sh - {1'b0, mb_q};
          quo_q <= {quo_q[iae_pkg::DIVD_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[iae_pkg::DIVD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      A_SAT: begin
        if (neg_q) begin
          if (wide > iae_pkg::PROD_W'(iae_pkg::MIN_NEG)) begin
            res_q <= iae_pkg::MIN_NEG;
            ovf_q <= 1'b1;
          end else begin
            res_q <= ~wide[iae_pkg::VAL_W-1:0] + 1'b1;
          end
        end else if (wide > iae_pkg::PROD_W'(iae_pkg::MAX_POS)) begin
          res_q <= iae_pkg::MAX_POS;
          ovf_q <= 1'b1;
        end else begin
          res_q <= wide[iae_pkg::VAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o = state_q == A_DONE;
  assign res_o  = res_q;
  assign ovf_o  = ovf_q;
  assign div0_o = div0_q;

endmodule

/* sv/iae_datapath.sv */
`timescale 1ns / 1ps
module iae_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  iae_pkg::dp_cmd_t          cmd_i,
  output iae_pkg::dp_stat_t         stat_o,
  output logic [iae_pkg::VAL_W-1:0] value_o
);

  logic [iae_pkg::VAL_W-1:0]   pending_q, pending_d;
  logic [iae_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [iae_pkg::VAL_W-1:0]   y_q, value_q;

  logic [iae_pkg::INT_W-1:0]     dig_add, t_int;
  logic [iae_pkg::SCALE_W+3:0]   prod_f;
  logic [iae_pkg::VAL_W:0]       t_frac;
  logic [31:0]                   scale_p5;
  logic [63:0]                   scale_div;
  logic                          ovf_int, ovf_frac;

  logic [iae_pkg::VAL_W-1:0] num_wdata, num_rdata, alu_res;
  logic [1:0]                op_rdata;
  logic                      alu_done, alu_ovf, alu_div0;

  assign dig_add = iae_pkg::INT_W'(cmd_i.digit) << iae_pkg::FRAC_BITS;
  assign t_int   = (iae_pkg::INT_W'(pending_q) << 3) + (iae_pkg::INT_W'(pending_q) << 1)
                 + dig_add;
  assign ovf_int = t_int > iae_pkg::INT_W'(iae_pkg::MAX_POS);

  assign prod_f   = (iae_pkg::SCALE_W+4)'(scale_q) * (iae_pkg::SCALE_W+4)'(cmd_i.digit);
  assign t_frac   = (iae_pkg::VAL_W+1)'(pending_q) + (iae_pkg::VAL_W+1)'(prod_f);
  assign ovf_frac = t_frac > (iae_pkg::VAL_W+1)'(iae_pkg::MAX_POS);

  // (scale + 5) / 10 by reciprocal multiply
  assign scale_p5  = 32'(scale_q) + 32'd5;
  assign scale_div = scale_p5 * iae_pkg::RECIP10;

  always_comb begin
    pending_d = pending_q;
    scale_d   = scale_q;
    unique case (cmd_i.dig)
      iae_pkg::DIG_START: begin
        pending_d = iae_pkg::VAL_W'(dig_add);
        scale_d   = iae_pkg::TENTH;
      end
      iae_pkg::DIG_INT: begin
        pending_d = ovf_int ? iae_pkg::MAX_POS : t_int[iae_pkg::VAL_W-1:0];
      end
      iae_pkg::DIG_FRAC: begin
        pending_d = ovf_frac ? iae_pkg::MAX_POS : t_frac[iae_pkg::VAL_W-1:0];
        scale_d   = iae_pkg::SCALE_W'(scale_div >> iae_pkg::RECIP_SH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      scale_q   <= iae_pkg::TENTH;
    end else begin
      pending_q <= pending_d;
      scale_q   <= scale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_y) begin
      y_q <= num_rdata;
    end
    if (cmd_i.out_load) begin
      value_q <= cmd_i.out_zero ? '0 : num_rdata;
    end
  end

  assign num_wdata = cmd_i.num_wsel_res ? alu_res : pending_q;

  iae_ram #(
    .WIDTH (iae_pkg::VAL_W),
    .DEPTH (iae_pkg::STACK_DEPTH)
  ) u_num_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.num_we),
    .waddr_i (cmd_i.num_waddr),
    .wdata_i (num_wdata),
    .raddr_i (cmd_i.num_raddr),
    .rdata_o (num_rdata)
  );

  iae_ram #(
    .WIDTH (2),
    .DEPTH (iae_pkg::STACK_DEPTH)
  ) u_op_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op_we),
    .waddr_i (cmd_i.op_waddr),
    .wdata_i (cmd_i.op_wdata),
    .raddr_i (cmd_i.op_raddr),
    .rdata_o (op_rdata)
  );

  iae_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.alu_start),
    .op_i    (iae_pkg::op_e'(op_rdata)),
    .x_i     (num_rdata),
    .y_i     (y_q),
    .done_o  (alu_done),
    .res_o   (alu_res),
    .ovf_o   (alu_ovf),
    .div0_o  (alu_div0)
  );

  always_comb begin
    stat_o.digit_ovf = ((cmd_i.dig == iae_pkg::DIG_INT) && ovf_int)
                    || ((cmd_i.dig == iae_pkg::DIG_FRAC) && ovf_frac);
    stat_o.alu_done  = alu_done;
    stat_o.alu_ovf   = alu_ovf;
    stat_o.alu_div0  = alu_div0;
    stat_o.op_top    = iae_pkg::op_e'(op_rdata);
  end

  assign value_o = value_q;

endmodule

/* sv/iae_ctrl.sv */
`timescale 1ns / 1ps
module iae_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [iae_pkg::CHAR_W-1:0] in_char_i,
  input  logic                       in_end_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 out_status_o,
  output iae_pkg::dp_cmd_t           cmd_o,
  input  iae_pkg::dp_stat_t          stat_i
);

  typedef enum logic [9:0] {
    S_IN    = 10'b0000000001,
    S_CHAR  = 10'b0000000010,
    S_RCHK  = 10'b0000000100,
    S_RD1   = 10'b0000001000,
    S_RD2   = 10'b0000010000,
    S_EXEC  = 10'b0000100000,
    S_PUSH  = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_OUTRD = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INT  = 2'd1,
    MODE_FRAC = 2'd2
  } mode_e;

  state_e                     state_q, state_d;
  logic [iae_pkg::CNT_W-1:0]  ncnt_q, ncnt_d, ocnt_q, ocnt_d;
  mode_e                      mode_q, mode_d;
  iae_pkg::status_e           err_q, err_d;
  iae_pkg::op_e               code_q, code_d;
  logic                       fin_q, fin_d;
  logic                       outv_q, outv_d;
  iae_pkg::status_e           status_q, status_d;
  logic [iae_pkg::CHAR_W-1:0] char_q;
  logic                       end_q;

  logic                       locked, accept;
  logic                       is_digit, is_op;
  iae_pkg::op_e               char_op;
  logic                       close_act, close_full;
  logic [iae_pkg::CNT_W-1:0]  ncnt_close;
  logic                       chain_ok;
  state_e                     nxt;

  assign locked = (err_q == iae_pkg::ST_DIV0) || (err_q == iae_pkg::ST_MALF);
  assign accept = in_valid_i && (state_q == S_IN);
  assign nxt    = end_q ? S_FIN : S_IN;

  assign is_digit = (char_q >= iae_pkg::CH_0) && (char_q <= iae_pkg::CH_9);

  always_comb begin
    is_op   = 1'b1;
    char_op = iae_pkg::OP_ADD;
    priority if (char_q == iae_pkg::CH_PLUS)  char_op = iae_pkg::OP_ADD;
    else if (char_q == iae_pkg::CH_MINUS)     char_op = iae_pkg::OP_SUB;
    else if (char_q == iae_pkg::CH_STAR)      char_op = iae_pkg::OP_MUL;
    else if (char_q == iae_pkg::CH_SLASH)     char_op = iae_pkg::OP_DIV;
    else                                      is_op   = 1'b0;
  end

  // a number in progress is pushed when it ends
  assign close_act  = mode_q != MODE_NONE;
  assign close_full = ncnt_q >= iae_pkg::CNT_W'(iae_pkg::STACK_DEPTH);
  assign ncnt_close = (close_act && !close_full) ? ncnt_q + 1'b1 : ncnt_q;
  assign chain_ok   = {1'b0, ncnt_close} == ({1'b0, ocnt_q} + 1'b1);

  always_comb begin
    state_d  = state_q;
    ncnt_d   = ncnt_q;
    ocnt_d   = ocnt_q;
    mode_d   = mode_q;
    err_d    = err_q;
    code_d   = code_q;
    fin_d    = fin_q;
    outv_d   = outv_q;
    status_d = status_q;

    cmd_o              = '0;
    cmd_o.num_waddr    = iae_pkg::ADDR_W'(ncnt_q);
    cmd_o.op_waddr     = iae_pkg::ADDR_W'(ocnt_q);
    cmd_o.op_wdata     = code_q;
    cmd_o.op_raddr     = iae_pkg::ADDR_W'(ocnt_q - 1'b1);
    cmd_o.digit        = 4'(char_q - iae_pkg::CH_0);

    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end

    unique case (state_q)
      S_IN: begin
        if (accept) begin
          state_d = S_CHAR;
        end
      end

      S_CHAR: begin
        state_d = nxt;
        if (!locked) begin
          if (is_digit) begin
            unique case (mode_q)
              MODE_NONE: begin
                if (ncnt_q != ocnt_q) begin
                  err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
                end else begin
                  cmd_o.dig = iae_pkg::DIG_START;
                  mode_d    = MODE_INT;
                end
              end
              MODE_INT: cmd_o.dig = iae_pkg::DIG_INT;
              default:  cmd_o.dig = iae_pkg::DIG_FRAC;
            endcase
            if (stat_i.digit_ovf) begin
              err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_OVF);
            end
          end else if (char_q == iae_pkg::CH_DOT) begin
            if (mode_q == MODE_INT) begin
              mode_d = MODE_FRAC;
            end else begin
              err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
            end
          end else if (is_op || char_q == iae_pkg::CH_SPACE) begin
            if (close_act) begin
              mode_d = MODE_NONE;
              if (close_full) begin
                err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
              end else begin
                cmd_o.num_we = 1'b1;
                ncnt_d       = ncnt_close;
              end
            end
            if (is_op && !(close_act && close_full)) begin
              if (!chain_ok) begin
                err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
              end else begin
                code_d  = char_op;
                fin_d   = 1'b0;
                state_d = S_RCHK;
              end
            end
          end else begin
            err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
          end
        end
      end

      S_FIN: begin
        state_d = S_OUTRD;
        if (!locked) begin
          if (close_act) begin
            mode_d = MODE_NONE;
            if (close_full) begin
              err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
            end else begin
              cmd_o.num_we = 1'b1;
              ncnt_d       = ncnt_close;
            end
          end
          if (!(close_act && close_full)) begin
            if (!chain_ok) begin
              err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
            end else begin
              fin_d   = 1'b1;
              state_d = S_RCHK;
            end
          end
        end
      end

      S_RCHK: begin
        cmd_o.num_raddr = iae_pkg::ADDR_W'(ncnt_q - 1'b1);
        if (locked || ocnt_q == '0) begin
          if (fin_q) begin
            state_d = S_OUTRD;
          end else begin
            state_d = locked ? nxt : S_PUSH;
          end
        end else begin
          state_d = S_RD1;
        end
      end

      S_RD1: begin
        // top operand and top operator are on the read ports now
        cmd_o.num_raddr = iae_pkg::ADDR_W'(ncnt_q - 2'd2);
        if (!fin_q && (stat_i.op_top[1] < code_q[1])) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.load_y = 1'b1;
          state_d      = S_RD2;
        end
      end

      S_RD2: begin
        cmd_o.num_raddr = iae_pkg::ADDR_W'(ncnt_q - 2'd2);
        cmd_o.alu_start = 1'b1;
        state_d         = S_EXEC;
      end

      S_EXEC: begin
        if (stat_i.alu_done) begin
          cmd_o.num_we       = 1'b1;
          cmd_o.num_wsel_res = 1'b1;
          cmd_o.num_waddr    = iae_pkg::ADDR_W'(ncnt_q - 2'd2);
          ncnt_d             = ncnt_q - 1'b1;
          ocnt_d             = ocnt_q - 1'b1;
          if (stat_i.alu_div0) begin
            err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_DIV0);
          end else if (stat_i.alu_ovf) begin
            err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_OVF);
          end
          state_d = S_RCHK;
        end
      end

      S_PUSH: begin
        state_d = nxt;
        if (ocnt_q >= iae_pkg::CNT_W'(iae_pkg::STACK_DEPTH)) begin
          err_d = iae_pkg::raise_err(err_q, iae_pkg::ST_MALF);
        end else begin
          cmd_o.op_we = 1'b1;
          ocnt_d      = ocnt_q + 1'b1;
        end
      end

      S_OUTRD: begin
        state_d = S_OUT;
      end

      S_OUT: begin
        // bottom of the number stack stays on the read port while stalled
        if (!outv_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = locked || (ncnt_q == '0);
          status_d       = err_q;
          outv_d         = 1'b1;
          ncnt_d         = '0;
          ocnt_d         = '0;
          mode_d         = MODE_NONE;
          err_d          = iae_pkg::ST_OK;
          state_d        = S_IN;
        end
      end

      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IN;
      ncnt_q   <= '0;
      ocnt_q   <= '0;
      mode_q   <= MODE_NONE;
      err_q    <= iae_pkg::ST_OK;
      code_q   <= iae_pkg::OP_ADD;
      fin_q    <= 1'b0;
      outv_q   <= 1'b0;
      status_q <= iae_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      ncnt_q   <= ncnt_d;
      ocnt_q   <= ocnt_d;
      mode_q   <= mode_d;
      err_q    <= err_d;
      code_q   <= code_d;
      fin_q    <= fin_d;
      outv_q   <= outv_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_char_i;
      end_q  <= in_end_i;
    end
  end

  assign in_ready_o   = state_q == S_IN;
  assign out_valid_o  = outv_q;
  assign out_status_o = status_q;

endmodule

/* sv/infix_arithmetic_evaluator.sv */
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                 tlast     tuser
// s_axis    in   char_code[7:0]                     end_mark  -
// m_axis    out  value[47:0], status[49:48], 0 pad  -         -
//
// A plain character (digit, space, '.') passes the input and decode states. An
// operator adds a precedence check and a push, and an operator or the last
// character adds the operand reads plus the arithmetic unit for every operator popped.
// The unit saturates sums directly, builds a product from four 24x24 partial products
// and divides with one quotient bit a cycle.
// Async active-low reset clears both stacks' counts; ready follows at once.
// A waiting result sits in the output register; the next expression is taken
// meanwhile and only its own result waits on m_axis_tready.
module infix_arithmetic_evaluator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [iae_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // char_code[7:0]
  input  logic                                s_axis_tlast,   // end_mark
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [iae_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // value[47:0], status[49:48]
);

  iae_pkg::dp_cmd_t          cmd;
  iae_pkg::dp_stat_t         stat;
  logic [iae_pkg::VAL_W-1:0] value;
  logic [1:0]                status;

  iae_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata[iae_pkg::CHAR_W-1:0]),
    .in_end_i     (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (status),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  iae_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .value_o (value)
  );

  assign m_axis_tdata = {(iae_pkg::OUT_TDATA_W - iae_pkg::VAL_W - 2)'(0), status, value};

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int  N_CHARS     = 1800;
  localparam int  QUIET_AFTER = N_CHARS * 85 / 100;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN       = 300;
  localparam longint ONE      = longint'(1) << iae_pkg::FRAC_BITS;
  localparam longint VMAX     = (longint'(1) << 47) - 1;
  localparam longint VMIN     = -(longint'(1) << 47);

  typedef enum int {NUM_NONE, NUM_INT, NUM_FRAC} num_mode_e;
  typedef struct {
    longint           value;
    iae_pkg::status_e status;
  } eval_result_t;
  typedef struct {
    string            text;
    bit               typed;
    longint           value;
    iae_pkg::status_e status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [iae_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [iae_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  infix_arithmetic_evaluator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // evaluator state mirror
  longint           num_stk[iae_pkg::STACK_DEPTH];
  iae_pkg::op_e     op_stk[iae_pkg::STACK_DEPTH];
  int               num_cnt, op_cnt;
  longint           pend_num;
  longint           frac_scale;
  num_mode_e        mode;
  iae_pkg::status_e err;

  eval_result_t results_due[$];
  int  chars_sent = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  long_hold_req = 1'b0;

  function automatic void clear_eval();
    num_cnt = 0;
    op_cnt = 0;
    pend_num = 0;
    frac_scale = longint'(iae_pkg::TENTH);
    mode = NUM_NONE;
    err = iae_pkg::ST_OK;
  endfunction

  function automatic void flag(iae_pkg::status_e code);
    if (err == iae_pkg::ST_OK || (err == iae_pkg::ST_OVF && code != iae_pkg::ST_OVF))
      err = code;
  endfunction

  function automatic bit is_locked();
    return err == iae_pkg::ST_DIV0 || err == iae_pkg::ST_MALF;
  endfunction

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat_mag(longint mag, bit neg);
    if (neg) begin
      if (mag > -VMIN) begin
        flag(iae_pkg::ST_OVF);
        return VMIN;
      end
      return -mag;
    end
    if (mag > VMAX) begin
      flag(iae_pkg::ST_OVF);
      return VMAX;
    end
    return mag;
  endfunction

  function automatic longint sat_sum(longint s);
    if (s > VMAX) begin
      flag(iae_pkg::ST_OVF);
      return VMAX;
    end
    if (s < VMIN) begin
      flag(iae_pkg::ST_OVF);
      return VMIN;
    end
    return s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    longint       mag;
    p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    // anything at or above 2^48 saturates either way
    if ((p >> (iae_pkg::FRAC_BITS + 48)) != 0) mag = -VMIN + 1;
    else mag = longint'(p[iae_pkg::FRAC_BITS +: 64]);
    return sat_mag(mag, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint unsigned ma, mb, q, r;
    ma = mag_of(a);
    mb = mag_of(b);
    if (mb == 0) begin
      flag(iae_pkg::ST_DIV0);
      return 0;
    end
    q = ma / mb;
    r = ma % mb;
    for (int i = 0; i < iae_pkg::FRAC_BITS; i++) begin
      if (q >= (64'd1 << 48)) break;
      q = q << 1;
      r = r << 1;
      if (r >= mb) begin
        r = r - mb;
        q = q | 1;
      end
    end
    return sat_mag(longint'(q), (a < 0) != (b < 0));
  endfunction

  function automatic void reduce_top();
    longint       x, y, r;
    iae_pkg::op_e op;
    if (num_cnt < 2 || op_cnt == 0) begin
      flag(iae_pkg::ST_MALF);
      return;
    end
    y = num_stk[num_cnt-1];
    x = num_stk[num_cnt-2];
    op = op_stk[op_cnt-1];
    num_cnt -= 2;
    op_cnt -= 1;
    case (op)
      iae_pkg::OP_ADD: r = sat_sum(x + y);
      iae_pkg::OP_SUB: r = sat_sum(x - y);
      iae_pkg::OP_MUL: r = fx_mul(x, y);
      default: r = fx_div(x, y);
    endcase
    num_stk[num_cnt] = r;
    num_cnt++;
  endfunction

  function automatic void close_num();
    if (mode == NUM_NONE) return;
    mode = NUM_NONE;
    if (num_cnt >= iae_pkg::STACK_DEPTH) begin
      flag(iae_pkg::ST_MALF);
      return;
    end
    num_stk[num_cnt] = pend_num;
    num_cnt++;
  endfunction

  function automatic void take_digit(int d);
    longint add;
    if (mode == NUM_NONE) begin
      if (num_cnt != op_cnt) begin
        flag(iae_pkg::ST_MALF);
        return;
      end
      mode = NUM_INT;
      pend_num = 0;
      frac_scale = longint'(iae_pkg::TENTH);
    end
    if (mode == NUM_INT) begin
      add = longint'(d) << iae_pkg::FRAC_BITS;
      if (pend_num > (VMAX - add) / 10) begin
        flag(iae_pkg::ST_OVF);
        pend_num = VMAX;
      end else begin
        pend_num = pend_num * 10 + add;
      end
    end else begin
      pend_num = sat_sum(pend_num + frac_scale * d);
      frac_scale = (frac_scale + 5) / 10;
    end
  endfunction

  function automatic void take_op(iae_pkg::op_e code);
    close_num();
    if (is_locked()) return;
    if (num_cnt != op_cnt + 1) begin
      flag(iae_pkg::ST_MALF);
      return;
    end
    while (op_cnt > 0 && !is_locked() && op_stk[op_cnt-1][1] >= code[1]) reduce_top();
    if (is_locked()) return;
    if (op_cnt >= iae_pkg::STACK_DEPTH) begin
      flag(iae_pkg::ST_MALF);
      return;
    end
    op_stk[op_cnt] = code;
    op_cnt++;
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (c >= iae_pkg::CH_0 && c <= iae_pkg::CH_9) take_digit(int'(c - iae_pkg::CH_0));
    else if (c == iae_pkg::CH_SPACE) close_num();
    else if (c == iae_pkg::CH_DOT) begin
      if (mode == NUM_INT) mode = NUM_FRAC;
      else flag(iae_pkg::ST_MALF);
    end
    else if (c == iae_pkg::CH_PLUS) take_op(iae_pkg::OP_ADD);
    else if (c == iae_pkg::CH_MINUS) take_op(iae_pkg::OP_SUB);
    else if (c == iae_pkg::CH_STAR) take_op(iae_pkg::OP_MUL);
    else if (c == iae_pkg::CH_SLASH) take_op(iae_pkg::OP_DIV);
    else flag(iae_pkg::ST_MALF);
  endfunction

  // returns 1 with the result when the character ends the expression
  function automatic bit eval_char(logic [7:0] c, bit last, output eval_result_t res);
    if (!is_locked()) take_char(c);
    if (!last) return 0;
    if (!is_locked()) begin
      close_num();
      if (!is_locked()) begin
        if (num_cnt != op_cnt + 1) flag(iae_pkg::ST_MALF);
        else while (op_cnt > 0 && !is_locked()) reduce_top();
      end
    end
    res.value = (!is_locked() && num_cnt > 0) ? num_stk[0] : 0;
    res.status = err;
    clear_eval();
    return 1;
  endfunction

  task automatic send_expr(logic [7:0] chars[$], bit typed = 0, longint v = 0,
                           iae_pkg::status_e st = iae_pkg::ST_OK);
    eval_result_t res;
    for (int i = 0; i < chars.size(); i++) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= chars[i];
      s_axis_tlast  <= (i == chars.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      chars_sent++;
      if (chars_sent == 300) long_hold_req = 1'b1;
      if (chars_sent >= QUIET_AFTER) quiet = 1'b1;
      if (eval_char(chars[i], i == chars.size() - 1, res)) begin
        if (typed) begin
          res.value = v;
          res.status = st;
        end
        results_due.push_back(res);
      end
    end
  endtask

  function automatic void add_str(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_number(ref logic [7:0] q[$]);
    int n_int;
    n_int = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 3);
    repeat (n_int) q.push_back(8'(iae_pkg::CH_0 + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      q.push_back(iae_pkg::CH_DOT);
      repeat ($urandom_range(0, 9)) q.push_back(8'(iae_pkg::CH_0 + $urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return iae_pkg::CH_PLUS;
      1: return iae_pkg::CH_MINUS;
      2: return iae_pkg::CH_STAR;
      default: return iae_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic void add_spaces(ref logic [7:0] q[$]);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) q.push_back(iae_pkg::CH_SPACE);
  endfunction

  function automatic void gen_expr(ref logic [7:0] q[$]);
    int kind, n_terms;
    q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_terms = $urandom_range(1, 5);
    add_spaces(q);
    for (int t = 0; t < n_terms; t++) begin
      if (t > 0) begin
        q.push_back(pick_op());
        add_spaces(q);
      end
      if ($urandom_range(0, 9) == 0) q.push_back(iae_pkg::CH_0);
      else add_number(q);
      add_spaces(q);
    end
    // broken forms: leading or trailing operator, stray character, two numbers
    case (kind)
      1: q.push_front(pick_op());
      2: q.push_back(pick_op());
      3: q.insert($urandom_range(0, q.size() - 1), 8'($urandom_range(0, 255)));
      4: begin
        q.push_back(iae_pkg::CH_SPACE);
        add_number(q);
      end
      default: ;
    endcase
  endfunction

  dir_row_t dir_rows[] = '{
    '{"0",                 1, 0,               iae_pkg::ST_OK},
    '{"1+2*3",             1, 7 * ONE,         iae_pkg::ST_OK},
    '{"8-2-3",             1, 3 * ONE,         iae_pkg::ST_OK},
    '{"12/4/3",            1, ONE,             iae_pkg::ST_OK},
    '{"2*3-4/2",           1, 4 * ONE,         iae_pkg::ST_OK},
    '{" 5 + 6 ",           1, 11 * ONE,        iae_pkg::ST_OK},
    '{"1.5*2",             0, 0,               iae_pkg::ST_OK},
    '{"7/0",               1, 0,               iae_pkg::ST_DIV0},
    '{"7/0+x",             1, 0,               iae_pkg::ST_DIV0},
    '{"-1",                1, 0,               iae_pkg::ST_MALF},
    '{"1 2",               1, 0,               iae_pkg::ST_MALF},
    '{"1.2.3",             1, 0,               iae_pkg::ST_MALF},
    '{".5",                1, 0,               iae_pkg::ST_MALF},
    '{"1+",                1, 0,               iae_pkg::ST_MALF},
    '{" ",                 1, 0,               iae_pkg::ST_MALF},
    '{"3a",                1, 0,               iae_pkg::ST_MALF},
    '{"1**2",              1, 0,               iae_pkg::ST_MALF},
    '{"8388607",           1, 8388607 * ONE,   iae_pkg::ST_OK},
    '{"99999999",          1, VMAX,            iae_pkg::ST_OVF},
    '{"8000000*8000000",   0, 0,               iae_pkg::ST_OK},
    '{"0-8000000*8000000", 0, 0,               iae_pkg::ST_OK},
    '{"1/3",               0, 0,               iae_pkg::ST_OK},
    '{"0.123456789",       0, 0,               iae_pkg::ST_OK},
    '{"99999999/0",        1, 0,               iae_pkg::ST_DIV0}
  };

  initial begin
    logic [7:0] q[$];
    clear_eval();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      q.delete();
      add_str(q, dir_rows[i].text);
      send_expr(q, dir_rows[i].typed, dir_rows[i].value, dir_rows[i].status);
    end
    q = '{8'h00};
    send_expr(q, 1, 0, iae_pkg::ST_MALF);
    q = '{8'hFF};
    send_expr(q, 1, 0, iae_pkg::ST_MALF);
    while (chars_sent < N_CHARS) begin
      gen_expr(q);
      send_expr(q);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // result side: check, then decide ready for the next cycle
  initial begin
    eval_result_t exp_res;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", m_axis_tdata);
        end else begin
          exp_res = results_due.pop_front();
          if (m_axis_tdata[47:0] !== exp_res.value[47:0] ||
              m_axis_tdata[49:48] !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                       exp_res.value[47:0], m_axis_tdata[47:0], exp_res.status,
                       m_axis_tdata[49:48]);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

/* sim.f */
sv/iae_pkg.sv
sv/iae_ram.sv
sv/iae_alu.sv
sv/iae_datapath.sv
sv/iae_ctrl.sv
sv/infix_arithmetic_evaluator.sv
verif/tb.sv
